### src/pscp_pkg.sv
package pscp_pkg;

  // Number of row or column labels of the square.
  localparam int NUM_LABELS = 5;

  // Configuration register indexes.
  localparam logic [2:0] REG_MODE    = 3'd0;
  localparam logic [2:0] REG_LABEL_0 = 3'd1;
  localparam logic [2:0] REG_LABEL_4 = 3'd5;

  // Mode codes.
  localparam logic MODE_ENCRYPT = 1'b0;
  localparam logic MODE_DECRYPT = 1'b1;

  // Character constants.
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_UPPER_I = 8'h49;
  localparam logic [7:0] CHAR_UPPER_J = 8'h4A;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;

  // Upper nibble of an ASCII digit; a label is appended as the low nibble.
  localparam logic [3:0] DIGIT_NIBBLE = 4'h3;

  // Square position of one letter.
  typedef struct packed {
    logic [2:0] row;
    logic [2:0] col;
  } pos_t;

  // One unit of work for the output side: one or two bytes.
  typedef struct packed {
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic       two;
  } job_t;

  // Square position of an upper-case letter given as its offset from 'A'.
  // J never arrives here, it has been folded onto I already.
  function automatic pos_t letter_pos(input logic [4:0] ofs);
    pos_t p;
    logic [4:0] lin;
    lin = (ofs > 5'd9) ? ofs - 5'd1 : ofs;
    case (lin)
      5'd0:    p = '{row: 3'd0, col: 3'd0};
      5'd1:    p = '{row: 3'd0, col: 3'd1};
      5'd2:    p = '{row: 3'd0, col: 3'd2};
      5'd3:    p = '{row: 3'd0, col: 3'd3};
      5'd4:    p = '{row: 3'd0, col: 3'd4};
      5'd5:    p = '{row: 3'd1, col: 3'd0};
      5'd6:    p = '{row: 3'd1, col: 3'd1};
      5'd7:    p = '{row: 3'd1, col: 3'd2};
      5'd8:    p = '{row: 3'd1, col: 3'd3};
      5'd9:    p = '{row: 3'd1, col: 3'd4};
      5'd10:   p = '{row: 3'd2, col: 3'd0};
      5'd11:   p = '{row: 3'd2, col: 3'd1};
      5'd12:   p = '{row: 3'd2, col: 3'd2};
      5'd13:   p = '{row: 3'd2, col: 3'd3};
      5'd14:   p = '{row: 3'd2, col: 3'd4};
      5'd15:   p = '{row: 3'd3, col: 3'd0};
      5'd16:   p = '{row: 3'd3, col: 3'd1};
      5'd17:   p = '{row: 3'd3, col: 3'd2};
      5'd18:   p = '{row: 3'd3, col: 3'd3};
      5'd19:   p = '{row: 3'd3, col: 3'd4};
      5'd20:   p = '{row: 3'd4, col: 3'd0};
      5'd21:   p = '{row: 3'd4, col: 3'd1};
      5'd22:   p = '{row: 3'd4, col: 3'd2};
      5'd23:   p = '{row: 3'd4, col: 3'd3};
      5'd24:   p = '{row: 3'd4, col: 3'd4};
      default: p = '{row: 3'd0, col: 3'd0};
    endcase
    return p;
  endfunction

  // Letter at a square position.
  function automatic logic [7:0] square_letter(input logic [2:0] row, input logic [2:0] col);
    logic [4:0] lin;
    lin = 5'(row) * 5'd5 + 5'(col);
    // Letters past I skip J.
    return (lin > 5'd8) ? CHAR_UPPER_A + 8'(lin) + 8'd1 : CHAR_UPPER_A + 8'(lin);
  endfunction

endpackage

### src/pscp_front.sv
module pscp_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [3:0]        cfg_data,
  input  logic              in_valid,
  input  logic [7:0]        in_byte,
  input  logic              message_end,
  input  logic              q_full,
  output logic              in_stall,
  output logic              push,
  output pscp_pkg::job_t    push_job
);
  import pscp_pkg::*;

  logic       mode;
  logic [3:0] key_label [NUM_LABELS];
  logic       row_pending;
  logic       row_pending_next;
  logic [3:0] held_row_digit;
  logic [3:0] held_row_digit_next;

  logic       accept;
  logic       has_result;
  job_t       job;

  logic [7:0] up_byte;
  logic       is_letter;
  logic       is_digit;
  pos_t       pos;
  logic       r_hit;
  logic [2:0] r_idx;
  logic       c_hit;
  logic [2:0] c_idx;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // Configuration registers; unused indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_ENCRYPT;
      for (int i = 0; i < NUM_LABELS; i++) begin
        key_label[i] <= 4'(i + 1);
      end
    end else if (cfg_we) begin
      if (cfg_index == REG_MODE) begin
        mode <= cfg_data[0];
      end else if (cfg_index <= REG_LABEL_4) begin
        key_label[3'(cfg_index - REG_LABEL_0)] <= cfg_data;
      end
    end
  end

  // Encrypt side: fold case and J, then find the square position.
  always_comb begin
    up_byte = in_byte;
    if (in_byte >= CHAR_LOWER_A && in_byte <= CHAR_LOWER_Z) begin
      up_byte = in_byte - CASE_OFFSET;
    end
    if (up_byte == CHAR_UPPER_J) begin
      up_byte = CHAR_UPPER_I;
    end
    is_letter = (up_byte >= CHAR_UPPER_A) && (up_byte <= CHAR_UPPER_Z);
    pos       = letter_pos(5'(up_byte - CHAR_UPPER_A));
  end

  assign is_digit = (in_byte >= CHAR_ZERO) && (in_byte <= CHAR_NINE);

  // Decrypt side: first label that matches the held row and the column byte.
  always_comb begin
    r_hit = 1'b0;
    r_idx = 3'd0;
    c_hit = 1'b0;
    c_idx = 3'd0;
    for (int i = NUM_LABELS - 1; i >= 0; i--) begin
      if (key_label[i] == held_row_digit) begin
        r_hit = 1'b1;
        r_idx = 3'(i);
      end
      if (in_byte == {DIGIT_NIBBLE, key_label[i]}) begin
        c_hit = 1'b1;
        c_idx = 3'(i);
      end
    end
  end

  // Classify the request and build its job.
  always_comb begin
    has_result          = 1'b0;
    job.byte0           = CHAR_SPACE;
    job.byte1           = CHAR_SPACE;
    job.two             = 1'b0;
    row_pending_next    = row_pending;
    held_row_digit_next = held_row_digit;
    if (mode == MODE_ENCRYPT) begin
      row_pending_next = 1'b0;
      has_result       = 1'b1;
      if (is_letter) begin
        job.byte0 = {DIGIT_NIBBLE, key_label[pos.row]};
        job.byte1 = {DIGIT_NIBBLE, key_label[pos.col]};
        job.two   = 1'b1;
      end
    end else if (row_pending) begin
      row_pending_next = 1'b0;
      if (r_hit && c_hit) begin
        has_result = 1'b1;
        job.byte0  = square_letter(r_idx, c_idx);
      end
    end else if (is_digit) begin
      row_pending_next    = 1'b1;
      held_row_digit_next = in_byte[3:0];
    end else begin
      has_result = 1'b1;
    end
    if (message_end) begin
      row_pending_next = 1'b0;
    end
  end

  assign push     = accept && has_result;
  assign push_job = job;

  // Held row state advances on each accepted request.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_pending    <= 1'b0;
      held_row_digit <= 4'd0;
    end else if (accept) begin
      row_pending    <= row_pending_next;
      held_row_digit <= held_row_digit_next;
    end
  end

endmodule

### src/pscp_queue.sv
module pscp_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  pscp_pkg::job_t push_job,
  input  logic           pop,
  output logic           full,
  output logic           not_empty,
  output pscp_pkg::job_t head
);
  import pscp_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### src/pscp_back.sv
module pscp_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_not_empty,
  input  pscp_pkg::job_t q_head,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     out_byte,
  output logic           run_last
);
  import pscp_pkg::*;

  logic       second_pend;
  logic [7:0] byte1_hold;
  logic       load;

  // The output register can take a new byte when empty or being drained.
  assign load = !out_valid || !out_stall;
  assign pop  = load && !second_pend && q_not_empty;

  // Control: output valid and the pending second byte of a pair.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      second_pend <= 1'b0;
    end else if (load) begin
      if (second_pend) begin
        out_valid   <= 1'b1;
        second_pend <= 1'b0;
      end else begin
        out_valid   <= q_not_empty;
        second_pend <= q_not_empty && q_head.two;
      end
    end
  end

  // Payload: first byte from the queue, second byte from the hold register.
  always_ff @(posedge clk) begin
    if (load) begin
      if (second_pend) begin
        out_byte <= byte1_hold;
        run_last <= 1'b1;
      end else if (q_not_empty) begin
        out_byte   <= q_head.byte0;
        run_last   <= !q_head.two;
        byte1_hold <= q_head.byte1;
      end
    end
  end

endmodule

### src/polybius_square_cipher.sv
// An accepted request's job is written into the queue, then loaded into the output register.
// Throughput: one result byte per cycle while out_stall is low; the two bytes of an
// encrypted letter leave the single output register in turn. A queue of QUEUE_DEPTH jobs
// lets requests keep coming while results wait.
// Reset (rst, synchronous, active high) empties the queue and output, clears the held
// row and loads mode encrypt and labels 1 to 5.
module polybius_square_cipher #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [3:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       message_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       run_last
);
  import pscp_pkg::*;

  logic q_full;
  logic q_not_empty;
  logic push;
  logic pop;
  job_t push_job;
  job_t q_head;

  // Front: configuration, held row and request classification.
  pscp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_byte     (in_byte),
    .message_end (message_end),
    .q_full      (q_full),
    .in_stall    (in_stall),
    .push        (push),
    .push_job    (push_job)
  );

  // Job queue between front and back.
  pscp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  // Back: serializes each job onto the output channel.
  pscp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .run_last    (run_last)
  );

endmodule

### src/pscp_checker.sv
module pscp_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       run_last
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(run_last))
    else $error("stalled result changed");

  // Reset leaves no result on the output.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result present after reset");

  // Only the first byte of a digit pair is not last, and it is a digit code.
  a_pair_digit: assert property (@(posedge clk) disable iff (rst)
    out_valid && !run_last |-> out_byte[7:4] == 4'h3)
    else $error("first byte of a pair is not a digit code");

  // The second byte of a pair follows right after the first is taken.
  a_pair_follow: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !run_last |=> out_valid && run_last)
    else $error("second byte of a pair did not follow");

endmodule

bind polybius_square_cipher pscp_checker u_checker (.*);

### tb/polybius_square_cipher_tb.sv
`timescale 1ns / 100ps

module polybius_square_cipher_tb;
  import pscp_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASES = 10;
  localparam int REQUESTS_PER_PHASE = 160;
  localparam int DIR_ROWS = 35;

  // Register indexes past the last label; writes to them must be ignored.
  localparam logic [2:0] REG_SPARE_LO = REG_LABEL_4 + 3'd1;
  localparam logic [2:0] REG_SPARE_HI = REG_LABEL_4 + 3'd2;

  // The square, row-major, first letter in the top byte.
  localparam logic [8*25-1:0] SQUARE_LETTERS = "ABCDEFGHIKLMNOPQRSTUVWXYZ";

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } cipher_out_t;

  typedef enum logic {ROW_WRITE, ROW_SEND} row_kind_e;

  // One directed step: a register write, or a request with optional typed-in results.
  typedef struct packed {
    row_kind_e  kind;
    logic [2:0] idx;
    logic [7:0] val;
    logic       eom;
    logic       pinned;
    logic [1:0] tn;
    logic [7:0] t0;
    logic [7:0] t1;
  } dir_row_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [3:0] cfg_data = '0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = '0;
  logic       message_end = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b1;
  logic [7:0] out_byte;
  logic       run_last;

  // Predictor state and configuration.
  logic       cfg_mode = MODE_ENCRYPT;
  logic [3:0] cfg_label [NUM_LABELS] = '{4'd1, 4'd2, 4'd3, 4'd4, 4'd5};
  logic       row_held = 1'b0;
  logic [3:0] row_digit = '0;

  cipher_out_t pending_chars [$];
  cipher_out_t step_chars [$];

  int mismatch_count = 0;
  int idle_cycles = 0;
  int send_idle = 0;
  int recv_idle = 0;

  dir_row_t directed_tab [DIR_ROWS] = '{
    '{ROW_SEND, '0, "A", 1'b0, 1'b1, 2'd2, "1", "1"},
    '{ROW_SEND, '0, "z", 1'b0, 1'b1, 2'd2, "5", "5"},
    '{ROW_SEND, '0, "J", 1'b0, 1'b1, 2'd2, "2", "4"},
    '{ROW_SEND, '0, "j", 1'b0, 1'b1, 2'd2, "2", "4"},
    '{ROW_SEND, '0, "K", 1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
    '{ROW_SEND, '0, 8'h00, 1'b0, 1'b1, 2'd1, " ", 8'h00},
    '{ROW_SEND, '0, "@", 1'b0, 1'b1, 2'd1, " ", 8'h00},
    '{ROW_SEND, '0, 8'hFF, 1'b1, 1'b1, 2'd1, " ", 8'h00},
    '{ROW_WRITE, REG_MODE, 8'(MODE_DECRYPT), 1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
    '{ROW_SEND, '0, "1", 1'b0, 1'b1, 2'd0, 8'h00, 8'h00},
    '{ROW_SEND, '0, "1", 1'b0, 1'b1, 2'd1, "A", 8'h00},
    '{ROW_SEND, '0, "5", 1'b0, 1'b1, 2'd0, 8'h00, 8'h00},
    '{ROW_SEND, '0, "5", 1'b0, 1'b1, 2'd1, "Z", 8'h00},
    '{ROW_SEND, '0, "0", 1'b0, 1'b1, 2'd0, 8'h00, 8'h00},
    '{ROW_SEND, '0, "x", 1'b0, 1'b1, 2'd0, 8'h00, 8'h00},
    '{ROW_SEND, '0, "3", 1'b1, 1'b1, 2'd0, 8'h00, 8'h00},
    '{ROW_SEND, '0, "B", 1'b0, 1'b1, 2'd1, " ", 8'h00},
    '{ROW_SEND, '0, "7", 1'b0, 1'b1, 2'd0, 8'h00, 8'h00},
    '{ROW_SEND, '0, "9", 1'b0, 1'b1, 2'd0, 8'h00, 8'h00},
    '{ROW_SEND, '0, "2", 1'b0, 1'b1, 2'd0, 8'h00, 8'h00},
    '{ROW_WRITE, REG_LABEL_0, 8'd9, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
    '{ROW_SEND, '0, "9", 1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
    '{ROW_WRITE, REG_LABEL_0, 8'd15, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
    '{ROW_WRITE, REG_MODE, 8'(MODE_ENCRYPT), 1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
    '{ROW_SEND, '0, "A", 1'b0, 1'b1, 2'd2, "?", "?"},
    '{ROW_WRITE, REG_LABEL_0, 8'd0, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
    '{ROW_WRITE, REG_SPARE_LO, 8'd15, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
    '{ROW_WRITE, REG_SPARE_HI, 8'd15, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
    '{ROW_SEND, '0, "A", 1'b0, 1'b1, 2'd2, "0", "0"},
    '{ROW_WRITE, REG_MODE, 8'(MODE_DECRYPT), 1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
    '{ROW_SEND, '0, "2", 1'b0, 1'b1, 2'd0, 8'h00, 8'h00},
    '{ROW_WRITE, REG_MODE, 8'(MODE_ENCRYPT), 1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
    '{ROW_SEND, '0, "B", 1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
    '{ROW_WRITE, REG_MODE, 8'(MODE_DECRYPT), 1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
    '{ROW_SEND, '0, "B", 1'b0, 1'b1, 2'd1, " ", 8'h00}
  };

  polybius_square_cipher u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_byte     (in_byte),
    .message_end (message_end),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .run_last    (run_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] square_at(input int k);
    return SQUARE_LETTERS[8*(24-k) +: 8];
  endfunction

  // First label index whose digit character equals ch, or NUM_LABELS if none.
  function automatic int label_of_char(input logic [7:0] ch);
    for (int i = 0; i < NUM_LABELS; i++) begin
      if (CHAR_ZERO + 8'(cfg_label[i]) == ch) return i;
    end
    return NUM_LABELS;
  endfunction

  // Advances the predictor by one request and leaves its characters in step_chars.
  function automatic void cipher_step(input logic [7:0] b_in, input logic eom);
    logic [7:0] b;
    int pos;
    int r;
    int c;
    b = b_in;
    pos = 25;
    step_chars.delete();
    if (cfg_mode == MODE_ENCRYPT) begin
      row_held = 1'b0;
      if (b >= CHAR_LOWER_A && b <= CHAR_LOWER_Z) b = b - CASE_OFFSET;
      if (b == CHAR_UPPER_J) b = CHAR_UPPER_I;
      if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) begin
        for (int k = 24; k >= 0; k--) begin
          if (square_at(k) == b) pos = k;
        end
        if (pos < 25) begin
          step_chars.push_back('{ch: CHAR_ZERO + 8'(cfg_label[pos / 5]), last: 1'b0});
          step_chars.push_back('{ch: CHAR_ZERO + 8'(cfg_label[pos % 5]), last: 1'b1});
        end
      end else begin
        step_chars.push_back('{ch: CHAR_SPACE, last: 1'b1});
      end
    end else if (row_held) begin
      // The byte after a held row digit is always taken as the column.
      row_held = 1'b0;
      r = label_of_char(CHAR_ZERO + 8'(row_digit));
      c = label_of_char(b);
      if (r < NUM_LABELS && c < NUM_LABELS)
        step_chars.push_back('{ch: square_at(r * 5 + c), last: 1'b1});
    end else if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
      row_held = 1'b1;
      row_digit = 4'(b - CHAR_ZERO);
    end else begin
      step_chars.push_back('{ch: CHAR_SPACE, last: 1'b1});
    end
    if (eom) row_held = 1'b0;
  endfunction

  function automatic int draw_gap(input int level);
    case (level)
      0: return 0;
      1: return $urandom_range(0, 2);
      default: return $urandom_range(0, 16);
    endcase
  endfunction

  // Sends one request, then records what it should produce once it is accepted.
  task automatic send_byte(input logic [7:0] b, input logic eom, input logic pinned,
                           input logic [1:0] tn, input logic [7:0] t0, input logic [7:0] t1);
    int gap;
    gap = draw_gap(send_idle);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    message_end <= eom;
    do @(posedge clk); while (in_stall);
    cipher_step(b, eom);
    if (pinned) begin
      if (tn == 2'd2) begin
        pending_chars.push_back('{ch: t0, last: 1'b0});
        pending_chars.push_back('{ch: t1, last: 1'b1});
      end else if (tn == 2'd1) begin
        pending_chars.push_back('{ch: t0, last: 1'b1});
      end
    end else begin
      foreach (step_chars[i]) pending_chars.push_back(step_chars[i]);
    end
  endtask

  // Waits until the block is idle, then writes one register.
  task automatic write_reg(input logic [2:0] idx, input logic [3:0] data);
    in_valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_MODE) begin
      cfg_mode = data[0];
    end else if (idx >= REG_LABEL_0 && idx <= REG_LABEL_4) begin
      cfg_label[idx - REG_LABEL_0] = data;
    end
  endtask

  // Stimulus: reset, directed table, then random phases under changing settings.
  initial begin
    logic [3:0] lab [NUM_LABELS];
    int digits [10];
    int kind;
    int sent;
    int pick;
    int j;
    int tmp;
    logic [3:0] lab_a;
    logic [3:0] lab_b;
    logic [7:0] b;
    logic phase_mode;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_tab[i]) begin
      if (directed_tab[i].kind == ROW_WRITE) begin
        write_reg(directed_tab[i].idx, directed_tab[i].val[3:0]);
      end else begin
        send_byte(directed_tab[i].val, directed_tab[i].eom, directed_tab[i].pinned,
                  directed_tab[i].tn, directed_tab[i].t0, directed_tab[i].t1);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      // Label sets: distinct digits, anything in range, all at the top, all at zero.
      kind = (p < 8) ? (p / 2) % 4 : $urandom_range(0, 3);
      phase_mode = (p % 2 == 1) ? MODE_DECRYPT : MODE_ENCRYPT;
      for (int k = 0; k < 10; k++) digits[k] = k;
      for (int k = 9; k > 0; k--) begin
        j = $urandom_range(0, k);
        tmp = digits[k];
        digits[k] = digits[j];
        digits[j] = tmp;
      end
      for (int k = 0; k < NUM_LABELS; k++) begin
        case (kind)
          0: lab[k] = 4'(digits[k]);
          1: lab[k] = 4'($urandom_range(0, 15));
          2: lab[k] = 4'd15;
          default: lab[k] = 4'd0;
        endcase
      end

      write_reg(REG_MODE, {3'($urandom_range(0, 7)), phase_mode});
      for (int k = 0; k < NUM_LABELS; k++) write_reg(REG_LABEL_0 + 3'(k), lab[k]);
      if ($urandom_range(0, 1) == 1)
        write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO,
                  4'($urandom_range(0, 15)));

      if (p == 3) begin
        send_idle = 0;
        recv_idle = 0;
      end else begin
        send_idle = $urandom_range(0, 2);
        recv_idle = $urandom_range(0, 2);
      end

      sent = 0;
      while (sent < REQUESTS_PER_PHASE) begin
        pick = $urandom_range(0, 9);
        if (phase_mode == MODE_ENCRYPT) begin
          if (pick < 7) begin
            b = CHAR_UPPER_A + 8'($urandom_range(0, 25));
            if ($urandom_range(0, 1) == 1) b = b + CASE_OFFSET;
          end else begin
            b = 8'($urandom_range(0, 255));
          end
          send_byte(b, $urandom_range(0, 19) == 0, 1'b0, '0, '0, '0);
          sent++;
        end else begin
          lab_a = cfg_label[$urandom_range(0, NUM_LABELS - 1)];
          lab_b = cfg_label[$urandom_range(0, NUM_LABELS - 1)];
          b = (lab_a <= 4'd9) ? CHAR_ZERO + 8'(lab_a) : CHAR_ZERO + 8'($urandom_range(0, 9));
          if (pick < 6) begin
            // Well-formed pair: a row digit, then a column character from the labels.
            send_byte(b, 1'b0, 1'b0, '0, '0, '0);
            send_byte(CHAR_ZERO + 8'(lab_b), $urandom_range(0, 19) == 0, 1'b0, '0, '0, '0);
            sent += 2;
          end else if (pick == 6) begin
            send_byte(b, 1'b0, 1'b0, '0, '0, '0);
            send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 19) == 0,
                      1'b0, '0, '0, '0);
            sent += 2;
          end else if (pick == 7) begin
            send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 19) == 0,
                      1'b0, '0, '0, '0);
            sent++;
          end else if (pick == 8) begin
            // A row digit that ends the message is dropped.
            send_byte(b, 1'b1, 1'b0, '0, '0, '0);
            sent++;
          end else begin
            send_byte(CHAR_ZERO + 8'($urandom_range(10, 15)), 1'b0, 1'b0, '0, '0, '0);
            sent++;
          end
        end
      end
    end

    in_valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("polybius_square_cipher_tb OK");
    else
      $display("polybius_square_cipher_tb NOT OK");
    $finish;
  end

  // Result side: stall for a random count of cycles before taking each result.
  initial begin
    int gap;
    do @(posedge clk); while (rst);
    forever begin
      gap = draw_gap(recv_idle);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // Compare every accepted result with the oldest expected character.
  always @(posedge clk) begin
    cipher_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_chars.size() == 0) begin
        $display("%0t: unexpected result out_byte=%h run_last=%b", $time, out_byte, run_last);
        mismatch_count++;
      end else begin
        want = pending_chars.pop_front();
        if (out_byte !== want.ch) begin
          $display("%0t: out_byte expected %h actual %h", $time, want.ch, out_byte);
          mismatch_count++;
        end
        if (run_last !== want.last) begin
          $display("%0t: run_last expected %b actual %b", $time, want.last, run_last);
          mismatch_count++;
        end
      end
    end
  end

  // End the run if nothing moves for too long.
  always @(posedge clk) begin
    if (rst || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("polybius_square_cipher_tb NOT OK");
      $finish;
    end
  end

endmodule
